// ===== design/command_token_decoder_defines.svh =====
// Assertion macros shared by the command token decoder RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef COMMAND_TOKEN_DECODER_DEFINES_SVH
`define COMMAND_TOKEN_DECODER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CTD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define CTD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ctd_pkg.sv =====
// Types and constants of the command token decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctd_pkg;

  typedef enum logic [1:0] {
    TYPE_KEYWORD = 2'd0,
    TYPE_NUMBER  = 2'd1,
    TYPE_STRING  = 2'd2
  } ctd_type_e;

  typedef enum logic [1:0] {
    KW_LOAD  = 2'd0,
    KW_STORE = 2'd1,
    KW_RESET = 2'd2
  } ctd_kw_e;

  localparam int unsigned NumKeywords = 3;
  localparam int unsigned KwMaxLen    = 5;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_A     = 8'h41;

  // Digit bias: 'A' - 10 for letters, '0' otherwise.
  localparam logic [31:0] BIAS_ALPHA = 32'd55;
  localparam logic [31:0] BIAS_DIGIT = 32'd48;

  localparam logic [7:0] KW_TEXT [NumKeywords][KwMaxLen] = '{
    '{"l", "o", "a", "d", 8'h00},
    '{"s", "t", "o", "r", "e"},
    '{"r", "e", "s", "e", "t"}
  };
  localparam logic [2:0] KW_LEN [NumKeywords] = '{3'd4, 3'd5, 3'd5};

  typedef struct packed {
    logic        token_valid;
    logic [1:0]  token_index;
    ctd_type_e   token_type;
    ctd_kw_e     keyword_code;
    logic [31:0] number_value;
    logic        message_end;
  } ctd_result_t;

endpackage

`default_nettype wire

// ===== design/ctd_front.sv =====
// Front end of the command token decoder: takes characters, tracks the
// current token and classifies it when it closes. Depends on ctd_pkg.
`default_nettype none
`include "command_token_decoder_defines.svh"

module ctd_front import ctd_pkg::*; #(
  parameter int unsigned MAX_TOKENS     = 3,
  parameter int unsigned MAX_HEX_DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  character_i,
  output logic             push_o,
  output ctd_result_t      result_o
);

  localparam int unsigned PosCeil = (MAX_HEX_DIGITS + 3 > 7) ? MAX_HEX_DIGITS + 3 : 7;
  localparam int unsigned PosW    = $clog2(PosCeil + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(PosCeil);
  localparam logic [PosW-1:0] HexEnd = PosW'(MAX_HEX_DIGITS + 2);
  localparam logic [PosW-1:0] PosNumMin = PosW'(3);
  localparam logic [1:0]      MaxTok = 2'(MAX_TOKENS);

  logic            in_token_q, in_token_d;
  logic [1:0]      tokens_q, tokens_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      match_q, match_d;
  logic [31:0]     acc_q, acc_d;
  logic            hex_ok_q, hex_ok_d;

  logic            is_nul, is_space;
  logic [PosW-1:0] cur_pos;
  logic [2:0]      cur_match, abs_match;
  logic [31:0]     cur_acc, abs_acc, digit;
  logic            cur_ok, abs_ok;
  logic [2:0]      p3;
  ctd_result_t     closed;

  assign is_nul   = (character_i == CHAR_NUL);
  assign is_space = (character_i == CHAR_SPACE);

  // A new token starts from cleared token state.
  assign cur_pos   = in_token_q ? pos_q    : '0;
  assign cur_match = in_token_q ? match_q  : 3'b111;
  assign cur_acc   = in_token_q ? acc_q    : '0;
  assign cur_ok    = in_token_q ? hex_ok_q : 1'b1;

  assign p3    = (cur_pos >= PosW'(KwMaxLen)) ? 3'd0 : cur_pos[2:0];
  assign digit = (character_i >= CHAR_A) ? ({24'b0, character_i} - BIAS_ALPHA)
                                         : ({24'b0, character_i} - BIAS_DIGIT);

  // Absorb one character into the token state.
  always_comb begin
    abs_match = cur_match;
    for (int k = 0; k < NumKeywords; k++) begin
      if ((cur_pos >= PosW'(KW_LEN[k])) || (character_i != KW_TEXT[k][p3])) begin
        abs_match[k] = 1'b0;
      end
    end
    abs_ok  = cur_ok;
    abs_acc = cur_acc;
    if (cur_pos == PosW'(0)) begin
      if (character_i != CHAR_ZERO) abs_ok = 1'b0;
    end else if (cur_pos == PosW'(1)) begin
      if (character_i != CHAR_X) abs_ok = 1'b0;
    end else if (cur_ok) begin
      if (cur_pos >= HexEnd) begin
        abs_ok = 1'b0;
      end else begin
        abs_acc = {cur_acc[27:0], 4'b0} + digit;
      end
    end
  end

  // Classify the open token; keywords take priority in list order.
  always_comb begin
    closed              = '0;
    closed.token_valid  = 1'b1;
    closed.token_index  = tokens_q;
    closed.token_type   = TYPE_STRING;
    closed.keyword_code = KW_LOAD;
    if (match_q[0] && (pos_q == PosW'(KW_LEN[0]))) begin
      closed.token_type = TYPE_KEYWORD;
    end else if (match_q[1] && (pos_q == PosW'(KW_LEN[1]))) begin
      closed.token_type   = TYPE_KEYWORD;
      closed.keyword_code = KW_STORE;
    end else if (match_q[2] && (pos_q == PosW'(KW_LEN[2]))) begin
      closed.token_type   = TYPE_KEYWORD;
      closed.keyword_code = KW_RESET;
    end else if (hex_ok_q && (pos_q >= PosNumMin)) begin
      closed.token_type   = TYPE_NUMBER;
      closed.number_value = acc_q;
    end
  end

  always_comb begin
    in_token_d = in_token_q;
    tokens_d   = tokens_q;
    pos_d      = pos_q;
    match_d    = match_q;
    acc_d      = acc_q;
    hex_ok_d   = hex_ok_q;
    push_o     = 1'b0;
    result_o   = '0;
    if (accept_i) begin
      if (is_nul) begin
        push_o = 1'b1;
        if (in_token_q) result_o = closed;
        result_o.message_end = 1'b1;
        in_token_d = 1'b0;
        tokens_d   = '0;
        pos_d      = '0;
        match_d    = 3'b111;
        acc_d      = '0;
        hex_ok_d   = 1'b1;
      end else if (is_space) begin
        if (in_token_q) begin
          push_o     = 1'b1;
          result_o   = closed;
          in_token_d = 1'b0;
          tokens_d   = tokens_q + 2'd1;
        end
      end else if (in_token_q || (tokens_q < MaxTok)) begin
        in_token_d = 1'b1;
        pos_d      = (cur_pos < PosMax) ? cur_pos + PosW'(1) : cur_pos;
        match_d    = abs_match;
        acc_d      = abs_acc;
        hex_ok_d   = abs_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      tokens_q   <= '0;
      pos_q      <= '0;
      match_q    <= 3'b111;
      acc_q      <= '0;
      hex_ok_q   <= 1'b1;
    end else begin
      in_token_q <= in_token_d;
      tokens_q   <= tokens_d;
      pos_q      <= pos_d;
      match_q    <= match_d;
      acc_q      <= acc_d;
      hex_ok_q   <= hex_ok_d;
    end
  end

  `CTD_ASSERT(a_tokens_bounded, tokens_q <= MaxTok, "token count beyond limit")
  `CTD_ASSERT_NEXT(a_nul_clears, accept_i && is_nul, !in_token_q && (tokens_q == 2'd0),
    "message end left token state behind")
  `CTD_ASSERT(a_push_kind, !push_o || result_o.token_valid || result_o.message_end,
    "result pushed with neither token nor message end")

endmodule

`default_nettype wire

// ===== design/ctd_queue.sv =====
// Short result queue between the front end and the output stage.
// Depends on ctd_pkg for the result type and depth.
`default_nettype none
`include "command_token_decoder_defines.svh"

module ctd_queue import ctd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  ctd_result_t       wdata_i,
  output logic              full_o,
  output logic              nempty_o,
  input  wire logic         pop_i,
  output ctd_result_t       rdata_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  ctd_result_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o   = (count_q == CntW'(QueueDepth));
  assign nempty_o = (count_q != '0);
  assign rdata_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (pop_i)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      if (push_i && !pop_i) count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  `CTD_ASSERT(a_no_underflow, !pop_i || nempty_o, "pop from empty queue")
  `CTD_ASSERT_NEXT(a_count_hold, push_i && pop_i, $stable(count_q),
    "push with pop changed the fill")

endmodule

`default_nettype wire

// ===== design/ctd_back.sv =====
// Output stage of the command token decoder: a result register that
// drains the queue. Depends on ctd_pkg for the result type.
`default_nettype none

module ctd_back import ctd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   avail_i,
  input  ctd_result_t data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output ctd_result_t out_data_o
);

  logic        valid_q;
  ctd_result_t data_q;

  // Load whenever the register is empty or its item leaves this cycle.
  assign pop_o       = avail_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= data_i;
  end

endmodule

`default_nettype wire

// ===== design/command_token_decoder.sv =====
// Command token decoder, top level: front end, result queue, output stage.
// Depends on ctd_pkg, ctd_front, ctd_queue and ctd_back.
`default_nettype none

// The block takes one message character per item and splits the message into
// space-delimited tokens. A zero byte ends the message; at most MAX_TOKENS
// tokens are taken and further characters are dropped until the zero byte.
// Each token that closes yields one result item giving its position and class:
// keyword (load, store, reset, case counted), number ("0x" plus one to
// MAX_HEX_DIGITS digits, accumulated modulo 2^32 without digit checks) or
// string. The zero byte always yields an item with message_end set, carrying
// the last token if one was open. Characters are taken at one per cycle while
// in_stall_o is low; a result passes through the queue and the output register
// before it appears on the output. The front end updates its running token
// state as each character is taken, so the sustained rate is set by the output
// side alone: a two-entry queue feeds the output register, and in_stall_o
// rises only when the queue is full because the consumer has held out_stall_i.

module command_token_decoder import ctd_pkg::*; #(
  parameter int unsigned MAX_TOKENS     = 3,
  parameter int unsigned MAX_HEX_DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  character_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             token_valid_o,
  output logic [1:0]       token_index_o,
  output logic [1:0]       token_type_o,
  output logic [1:0]       keyword_code_o,
  output logic [31:0]      number_value_o,
  output logic             message_end_o
);

  logic        accept;
  logic        push, q_full, q_nempty, pop;
  ctd_result_t front_res, q_res, out_res;

  // Hold the character channel only while the queue has no room.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  ctd_front #(
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .push_o      (push),
    .result_o    (front_res)
  );

  ctd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (front_res),
    .full_o   (q_full),
    .nempty_o (q_nempty),
    .pop_i    (pop),
    .rdata_o  (q_res)
  );

  ctd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_nempty),
    .data_i      (q_res),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  // Unpack the result item onto its ports.
  assign token_valid_o  = out_res.token_valid;
  assign token_index_o  = out_res.token_index;
  assign token_type_o   = out_res.token_type;
  assign keyword_code_o = out_res.keyword_code;
  assign number_value_o = out_res.number_value;
  assign message_end_o  = out_res.message_end;

endmodule

`default_nettype wire
